// ----- rtl/core/fqc_pkg.sv -----
// Shared widths, command and status codes, and interface structs for the
// handle queue. No dependencies.
`timescale 1ns / 1ps

package fqc_pkg;

    localparam int HANDLE_W     = 8;
    localparam int HANDLE_COUNT = 1 << HANDLE_W;
    localparam int LEN_W        = HANDLE_W + 1;
    localparam int CNT_W        = 32;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;

    localparam int S_FIELDS_W = CMD_W + HANDLE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = STATUS_W + HANDLE_W + LEN_W + 2 * CNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CANCEL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP     = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;

    typedef struct packed {
        logic                en;
        logic [HANDLE_W-1:0] addr;
        logic [HANDLE_W-1:0] data;
    } link_wr_t;

    typedef struct packed {
        logic                en;
        logic [HANDLE_W-1:0] addr;
    } link_rd_t;

    typedef struct packed {
        logic [CNT_W-1:0]    cancelled_total;
        logic [CNT_W-1:0]    popped_total;
        logic [LEN_W-1:0]    queue_length;
        logic [HANDLE_W-1:0] popped_handle;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

// ----- rtl/core/fqc_link_mem.sv -----
// Successor-link memory for the handle queue: one write and one registered
// read port. Depends on fqc_pkg.
`timescale 1ns / 1ps

module fqc_link_mem
    import fqc_pkg::*;
(
    input  logic                aclk,
    input  link_wr_t            wr,
    input  link_rd_t            rd,
    output logic [HANDLE_W-1:0] rd_data
);

    logic [HANDLE_W-1:0] link_mem [HANDLE_COUNT];
    logic [HANDLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            link_mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rd_data_reg <= link_mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/fqc_ctrl.sv -----
// Command sequencer for the handle queue: head, tail, length, membership
// flags and counters; walks the link memory. Depends on fqc_pkg.
`timescale 1ns / 1ps

module fqc_ctrl
    import fqc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    in_cmd,
    input  logic [HANDLE_W-1:0] in_handle,
    output logic                res_valid,
    input  logic                res_ready,
    output result_t             res,
    output link_wr_t            link_wr,
    output link_rd_t            link_rd,
    input  logic [HANDLE_W-1:0] link_rdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP_WAIT,
        ST_HEAD_WAIT,
        ST_WALK,
        ST_UNLINK,
        ST_RESP
    } state_t;

    state_t                  state_reg;
    logic [CMD_W-1:0]        cmd_reg;
    logic [HANDLE_W-1:0]     handle_reg;
    logic [HANDLE_W-1:0]     prev_reg;
    logic [HANDLE_W-1:0]     head_reg;
    logic [HANDLE_W-1:0]     tail_reg;
    logic [LEN_W-1:0]        len_reg;
    logic [CNT_W-1:0]        pop_cnt_reg;
    logic [CNT_W-1:0]        cancel_cnt_reg;
    logic [HANDLE_COUNT-1:0] queued_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic [HANDLE_W-1:0]     popped_reg;

    logic queued_hit;
    logic len_multi;
    logic len_zero;

    assign queued_hit = queued_reg[handle_reg];
    assign len_multi  = (len_reg > LEN_W'(1));
    assign len_zero   = (len_reg == '0);

    always_comb begin
        link_wr = '0;
        link_rd = '0;
        unique case (state_reg)
            ST_EXEC: begin
                case (cmd_reg)
                    CMD_ENQUEUE: begin
                        if (!queued_hit && !len_zero) begin
                            link_wr = '{en: 1'b1, addr: tail_reg, data: handle_reg};
                        end
                    end
                    CMD_CANCEL: begin
                        if (queued_hit) begin
                            if (head_reg != handle_reg) begin
                                link_rd = '{en: 1'b1, addr: head_reg};
                            end else if (len_multi) begin
                                link_rd = '{en: 1'b1, addr: handle_reg};
                            end
                        end
                    end
                    CMD_POP: begin
                        if (len_multi) begin
                            link_rd = '{en: 1'b1, addr: head_reg};
                        end
                    end
                    default: ;
                endcase
            end
            ST_WALK: begin
                if (link_rdata != handle_reg) begin
                    link_rd = '{en: 1'b1, addr: link_rdata};
                end else if (handle_reg != tail_reg) begin
                    link_rd = '{en: 1'b1, addr: handle_reg};
                end
            end
            ST_UNLINK: begin
                link_wr = '{en: 1'b1, addr: prev_reg, data: link_rdata};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cmd_reg        <= '0;
            handle_reg     <= '0;
            prev_reg       <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            len_reg        <= '0;
            pop_cnt_reg    <= '0;
            cancel_cnt_reg <= '0;
            queued_reg     <= '0;
            status_reg     <= STATUS_DONE;
            popped_reg     <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        cmd_reg    <= in_cmd;
                        handle_reg <= in_handle;
                        state_reg  <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    popped_reg <= '0;
                    status_reg <= STATUS_IGNORED;
                    state_reg  <= ST_RESP;
                    unique case (cmd_reg)
                        CMD_ENQUEUE: begin
                            if (!queued_hit) begin
                                if (len_zero) begin
                                    head_reg <= handle_reg;
                                end
                                tail_reg               <= handle_reg;
                                queued_reg[handle_reg] <= 1'b1;
                                len_reg                <= len_reg + LEN_W'(1);
                                status_reg             <= STATUS_DONE;
                            end
                        end
                        CMD_CANCEL: begin
                            if (queued_hit) begin
                                if (head_reg != handle_reg) begin
                                    prev_reg  <= head_reg;
                                    state_reg <= ST_WALK;
                                end else if (len_multi) begin
                                    state_reg <= ST_HEAD_WAIT;
                                end else begin
                                    head_reg               <= '0;
                                    tail_reg               <= '0;
                                    queued_reg[handle_reg] <= 1'b0;
                                    len_reg                <= len_reg - LEN_W'(1);
                                    cancel_cnt_reg         <= cancel_cnt_reg + CNT_W'(1);
                                    status_reg             <= STATUS_DONE;
                                end
                            end
                        end
                        CMD_POP: begin
                            if (len_zero) begin
                                status_reg <= STATUS_EMPTY;
                            end else begin
                                popped_reg           <= head_reg;
                                queued_reg[head_reg] <= 1'b0;
                                len_reg              <= len_reg - LEN_W'(1);
                                pop_cnt_reg          <= pop_cnt_reg + CNT_W'(1);
                                status_reg           <= STATUS_DONE;
                                if (len_multi) begin
                                    state_reg <= ST_POP_WAIT;
                                end else begin
                                    head_reg <= '0;
                                    tail_reg <= '0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                ST_POP_WAIT: begin
                    head_reg  <= link_rdata;
                    state_reg <= ST_RESP;
                end
                ST_HEAD_WAIT: begin
                    head_reg               <= link_rdata;
                    queued_reg[handle_reg] <= 1'b0;
                    len_reg                <= len_reg - LEN_W'(1);
                    cancel_cnt_reg         <= cancel_cnt_reg + CNT_W'(1);
                    status_reg             <= STATUS_DONE;
                    state_reg              <= ST_RESP;
                end
                ST_WALK: begin
                    if (link_rdata != handle_reg) begin
                        prev_reg <= link_rdata;
                    end else if (handle_reg == tail_reg) begin
                        tail_reg               <= prev_reg;
                        queued_reg[handle_reg] <= 1'b0;
                        len_reg                <= len_reg - LEN_W'(1);
                        cancel_cnt_reg         <= cancel_cnt_reg + CNT_W'(1);
                        status_reg             <= STATUS_DONE;
                        state_reg              <= ST_RESP;
                    end else begin
                        state_reg <= ST_UNLINK;
                    end
                end
                ST_UNLINK: begin
                    queued_reg[handle_reg] <= 1'b0;
                    len_reg                <= len_reg - LEN_W'(1);
                    cancel_cnt_reg         <= cancel_cnt_reg + CNT_W'(1);
                    status_reg             <= STATUS_DONE;
                    state_reg              <= ST_RESP;
                end
                ST_RESP: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESP);

    always_comb begin
        res.status          = status_reg;
        res.popped_handle   = popped_reg;
        res.queue_length    = len_reg;
        res.popped_total    = pop_cnt_reg;
        res.cancelled_total = cancel_cnt_reg;
    end

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(HANDLE_COUNT))
        else $error("queue length beyond handle count");

    a_flags_match_len: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(queued_reg) == int'(len_reg))
        else $error("membership flags disagree with queue length");

    a_walk_multi: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> len_multi)
        else $error("list walk on a queue of fewer than two handles");

    a_single_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(link_wr.en && link_rd.en))
        else $error("link memory read and written in one cycle");

    a_empty_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE && len_zero |-> head_reg == '0 && tail_reg == '0)
        else $error("head or tail not cleared on empty queue");

endmodule

// ----- rtl/core/fifo_queue_with_cancel.sv -----
// Top level of the handle queue: stream ports, result register, sequencer
// and link memory. Depends on fqc_pkg, fqc_ctrl and fqc_link_mem.
`timescale 1ns / 1ps

// Linked-list FIFO of handle ids with enqueue, cancel anywhere and pop.
// One command is in work at a time; each gives exactly one result item,
// and a new command is taken while the previous result waits at m_.
// The cancel walk follows successor links from the head, reading the link
// memory one entry a cycle through its registered read port; pop and
// cancel of the head fetch the new head the same way. Membership flags sit
// in flip-flops cleared at reset, so no clearing pass follows reset.

module fifo_queue_with_cancel
    import fqc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // cmd, handle_id
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // status, popped_handle, queue_length,
                                           // popped_total, cancelled_total
);

    logic                res_valid;
    logic                res_ready;
    result_t             res;
    link_wr_t            link_wr;
    link_rd_t            link_rd;
    logic [HANDLE_W-1:0] link_rdata;
    logic                out_valid_reg;
    result_t             out_data_reg;

    fqc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tdata[CMD_W-1:0]),
        .in_handle  (s_tdata[CMD_W+HANDLE_W-1:CMD_W]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .link_wr    (link_wr),
        .link_rd    (link_rd),
        .link_rdata (link_rdata)
    );

    fqc_link_mem u_link_mem (
        .aclk    (aclk),
        .wr      (link_wr),
        .rd      (link_rd),
        .rd_data (link_rdata)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, out_data_reg};

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for fifo_queue_with_cancel: directed table, full fill and drain,
// then random command streams, most with stalls on both sides, all checked per field.
// Depends on fqc_pkg and the fifo_queue_with_cancel RTL.
`timescale 1ns / 1ps

module tb;
    import fqc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int LONG_HOLD_AT  = 100;
    localparam int LONG_HOLD_LEN = 500;

    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [HANDLE_W-1:0] handle;
        bit                  typed;
        result_t             want;
    } dir_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // queue state as the block should hold it
    logic [HANDLE_W-1:0] succ [HANDLE_COUNT];
    bit                  in_queue [HANDLE_COUNT];
    logic [HANDLE_W-1:0] q_head;
    logic [HANDLE_W-1:0] q_tail;
    logic [LEN_W-1:0]    q_len;
    logic [CNT_W-1:0]    pop_cnt;
    logic [CNT_W-1:0]    cancel_cnt;

    result_t  pending [$];
    dir_row_t dir_rows [$];
    int       fail_count     = 0;
    int       sent_count     = 0;
    int       cycle_count    = 0;
    bit       calm           = 1'b0;
    bit       long_hold_done = 1'b0;

    fifo_queue_with_cancel i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic result_t queue_step(logic [CMD_W-1:0] c, logic [HANDLE_W-1:0] h);
        result_t             r;
        logic [HANDLE_W-1:0] cur;
        logic [HANDLE_W-1:0] prev;
        bit                  found;
        bit                  have_prev;
        int                  i;
        r = '0;
        r.status = STATUS_IGNORED;
        case (c)
            CMD_ENQUEUE: begin
                if (!in_queue[h]) begin
                    if (q_len == 0) q_head = h;
                    else succ[q_tail] = h;
                    q_tail = h;
                    in_queue[h] = 1'b1;
                    q_len = q_len + 1'b1;
                    r.status = STATUS_DONE;
                end
            end
            CMD_CANCEL: begin
                if (in_queue[h] && q_len != 0) begin
                    cur = q_head;
                    prev = '0;
                    have_prev = 1'b0;
                    found = 1'b0;
                    for (i = 0; i < q_len && !found; i++) begin
                        if (cur == h) begin
                            found = 1'b1;
                        end else begin
                            prev = cur;
                            have_prev = 1'b1;
                            cur = succ[cur];
                        end
                    end
                    if (found) begin
                        if (!have_prev) begin
                            if (q_len > 1) begin
                                q_head = succ[h];
                            end else begin
                                q_head = '0;
                                q_tail = '0;
                            end
                        end else if (h == q_tail) begin
                            q_tail = prev;
                        end else begin
                            succ[prev] = succ[h];
                        end
                        in_queue[h] = 1'b0;
                        q_len = q_len - 1'b1;
                        cancel_cnt = cancel_cnt + 1'b1;
                        r.status = STATUS_DONE;
                    end
                end
            end
            CMD_POP: begin
                if (q_len == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    cur = q_head;
                    if (q_len > 1) begin
                        q_head = succ[cur];
                    end else begin
                        q_head = '0;
                        q_tail = '0;
                    end
                    in_queue[cur] = 1'b0;
                    q_len = q_len - 1'b1;
                    pop_cnt = pop_cnt + 1'b1;
                    r.popped_handle = cur;
                    r.status = STATUS_DONE;
                end
            end
            default: r.status = STATUS_IGNORED;
        endcase
        r.queue_length    = q_len;
        r.popped_total    = pop_cnt;
        r.cancelled_total = cancel_cnt;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [CNT_W-1:0] got,
                                   input logic [CNT_W-1:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h",
                 cycle_count, field, got, want);
        fail_count++;
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [HANDLE_W-1:0] h,
                            input bit typed, input result_t want);
        int      gap;
        result_t pred;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({h, c});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = queue_step(c, h);
        pending.push_back(typed ? want : pred);
        sent_count++;
    endtask

    task automatic send_plain(input logic [CMD_W-1:0] c, input logic [HANDLE_W-1:0] h);
        send_cmd(c, h, 1'b0, '0);
    endtask

    // hold the input idle until every outstanding item has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending.size() != 0) @(posedge aclk);
    endtask

    task automatic add_row(input logic [CMD_W-1:0] c, input logic [HANDLE_W-1:0] h,
                           input bit typed, input logic [STATUS_W-1:0] st,
                           input logic [LEN_W-1:0] len);
        dir_row_t row;
        row.cmd    = c;
        row.handle = h;
        row.typed  = typed;
        row.want   = '0;
        row.want.status       = st;
        row.want.queue_length = len;
        dir_rows.push_back(row);
    endtask

    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[M_FIELDS_W-1:0]);
            if (pending.size() == 0) begin
                report_mismatch("unexpected item status", CNT_W'(got.status), '0);
            end else begin
                want = pending.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", CNT_W'(got.status), CNT_W'(want.status));
                if (got.popped_handle != want.popped_handle)
                    report_mismatch("popped_handle", CNT_W'(got.popped_handle),
                                    CNT_W'(want.popped_handle));
                if (got.queue_length != want.queue_length)
                    report_mismatch("queue_length", CNT_W'(got.queue_length),
                                    CNT_W'(want.queue_length));
                if (got.popped_total != want.popped_total)
                    report_mismatch("popped_total", got.popped_total, want.popped_total);
                if (got.cancelled_total != want.cancelled_total)
                    report_mismatch("cancelled_total", got.cancelled_total,
                                    want.cancelled_total);
            end
        end
    end

    initial begin : result_accept
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (!long_hold_done && sent_count >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                stall = LONG_HOLD_LEN;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                    : $urandom_range(1, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int                  i;
        int                  j;
        int                  k;
        int                  r;
        int                  blk;
        int                  pool_n;
        int                  enq_w;
        int                  perm [HANDLE_COUNT];
        logic [HANDLE_W-1:0] pool [40];
        logic [HANDLE_W-1:0] h;
        logic [CMD_W-1:0]    c;

        for (i = 0; i < HANDLE_COUNT; i++) begin
            succ[i] = '0;
            in_queue[i] = 1'b0;
        end
        q_head = '0;
        q_tail = '0;
        q_len = '0;
        pop_cnt = '0;
        cancel_cnt = '0;

        add_row(CMD_POP,     8'h00, 1'b1, STATUS_EMPTY,   9'd0);
        add_row(CMD_UNUSED,  8'hFF, 1'b1, STATUS_IGNORED, 9'd0);
        add_row(CMD_CANCEL,  8'h00, 1'b1, STATUS_IGNORED, 9'd0);
        add_row(CMD_ENQUEUE, 8'h00, 1'b1, STATUS_DONE,    9'd1);
        add_row(CMD_ENQUEUE, 8'hFF, 1'b1, STATUS_DONE,    9'd2);
        add_row(CMD_ENQUEUE, 8'h00, 1'b1, STATUS_IGNORED, 9'd2);
        add_row(CMD_ENQUEUE, 8'hAA, 1'b0, STATUS_DONE,    9'd0);
        add_row(CMD_ENQUEUE, 8'h55, 1'b0, STATUS_DONE,    9'd0);
        add_row(CMD_ENQUEUE, 8'h80, 1'b0, STATUS_DONE,    9'd0);
        add_row(CMD_ENQUEUE, 8'h01, 1'b0, STATUS_DONE,    9'd0);
        add_row(CMD_CANCEL,  8'h01, 1'b0, STATUS_DONE,    9'd0);
        add_row(CMD_CANCEL,  8'hAA, 1'b0, STATUS_DONE,    9'd0);
        add_row(CMD_CANCEL,  8'h00, 1'b0, STATUS_DONE,    9'd0);
        add_row(CMD_POP,     8'h3C, 1'b0, STATUS_DONE,    9'd0);
        add_row(CMD_CANCEL,  8'h55, 1'b0, STATUS_DONE,    9'd0);
        add_row(CMD_POP,     8'h00, 1'b0, STATUS_DONE,    9'd0);
        add_row(CMD_POP,     8'h00, 1'b0, STATUS_DONE,    9'd0);
        add_row(CMD_ENQUEUE, 8'h07, 1'b0, STATUS_DONE,    9'd0);
        add_row(CMD_CANCEL,  8'h07, 1'b0, STATUS_DONE,    9'd0);
        add_row(CMD_CANCEL,  8'h07, 1'b0, STATUS_DONE,    9'd0);
        add_row(CMD_UNUSED,  8'h5A, 1'b0, STATUS_DONE,    9'd0);
        add_row(CMD_ENQUEUE, 8'h33, 1'b0, STATUS_DONE,    9'd0);
        add_row(CMD_POP,     8'hC3, 1'b0, STATUS_DONE,    9'd0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_cmd(dir_rows[i].cmd, dir_rows[i].handle, dir_rows[i].typed,
                     dir_rows[i].want);
        drain();

        // fill every handle in shuffled order, unlink deep entries, then empty it
        for (i = 0; i < HANDLE_COUNT; i++) perm[i] = i;
        for (i = HANDLE_COUNT - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            k = perm[i];
            perm[i] = perm[j];
            perm[j] = k;
        end
        calm = 1'b1;
        for (i = 0; i < HANDLE_COUNT; i++) send_plain(CMD_ENQUEUE, HANDLE_W'(perm[i]));
        calm = 1'b0;
        send_plain(CMD_ENQUEUE, HANDLE_W'(perm[17]));
        send_plain(CMD_CANCEL, HANDLE_W'(perm[HANDLE_COUNT - 1]));
        send_plain(CMD_CANCEL, HANDLE_W'(perm[250]));
        send_plain(CMD_CANCEL, HANDLE_W'(perm[0]));
        send_plain(CMD_CANCEL, HANDLE_W'(perm[HANDLE_COUNT - 1]));
        send_plain(CMD_ENQUEUE, HANDLE_W'(perm[HANDLE_COUNT - 1]));
        for (i = 0; i < HANDLE_COUNT - 1; i++)
            send_plain(CMD_POP, HANDLE_W'($urandom_range(0, 255)));
        drain();

        for (blk = 0; blk < 4; blk++) begin
            calm   = (blk % 3 == 1);
            pool_n = (blk == 3) ? 40 : 12;
            enq_w  = (blk == 3) ? 55 : 40;
            for (i = 0; i < pool_n; i++) pool[i] = HANDLE_W'($urandom_range(0, 255));
            for (i = 0; i < 40; i++) begin
                r = $urandom_range(0, 99);
                if (r < enq_w) c = CMD_ENQUEUE;
                else if (r < enq_w + 25) c = CMD_CANCEL;
                else if (r < 95) c = CMD_POP;
                else c = CMD_UNUSED;
                if ($urandom_range(0, 3) != 0) h = pool[$urandom_range(0, pool_n - 1)];
                else h = HANDLE_W'($urandom_range(0, 255));
                send_plain(c, h);
            end
        end
        calm = 1'b0;

        drain();
        repeat (300) @(posedge aclk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/fqc_pkg.sv
rtl/core/fqc_link_mem.sv
rtl/core/fqc_ctrl.sv
rtl/core/fifo_queue_with_cancel.sv
tb/tb.sv
